### hdl/bdb_pkg.sv
// Shared constants, codes and the knot function for the B-spline evaluator.
// No dependencies; imported by the evaluator top level.
package bdb_pkg;

    // Spline size and number format
    localparam int MAX_POINTS = 64;
    localparam int DEGREE     = 3;
    localparam int FRAC_BITS  = 16;

    // Field widths
    localparam int CMDW = 2;
    localparam int PTW  = 32;
    localparam int XW   = 23;
    localparam int STW  = 3;

    // Derived widths
    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int IW   = $clog2(MAX_POINTS + 2 * DEGREE + 1);
    localparam int KW   = $clog2(DEGREE + 1);
    localparam int LW   = $clog2(DEGREE + 2);
    localparam int QCW  = $clog2(XW);
    localparam int DW   = PTW + 1;
    localparam int PW   = DW + XW + 1;
    localparam int NUMW = ((CW + FRAC_BITS) > XW) ? (CW + FRAC_BITS) : XW;

    // Command codes
    localparam logic [CMDW-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMDW-1:0] CMD_EVAL  = 2'd1;
    localparam logic [CMDW-1:0] CMD_RESET = 2'd2;

    // Status codes
    localparam logic [STW-1:0] ST_POINT = 3'd0;
    localparam logic [STW-1:0] ST_ADDED = 3'd1;
    localparam logic [STW-1:0] ST_FULL  = 3'd2;
    localparam logic [STW-1:0] ST_EMPTY = 3'd3;
    localparam logic [STW-1:0] ST_RESET = 3'd4;

    // Clamped uniform knot value (whole number) at index idx for n points
    function automatic logic [CW-1:0] knot_at(input logic [IW-1:0] idx,
                                              input logic [CW-1:0] n);
        logic [CW-1:0] k;
        if (idx <= IW'(DEGREE)) begin
            k = '0;
        end else if (idx >= IW'(n)) begin
            k = n - CW'(DEGREE);
        end else begin
            k = CW'(idx - IW'(DEGREE));
        end
        return k;
    endfunction

endpackage

### hdl/bdb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/bspline_de_boor_evaluator.sv
// Clamped B-spline store and de Boor evaluator on one shared divide/multiply unit.
// Add writes the point (the first add fills DEGREE+1 entries); reset and refused words go straight to the result.
// Evaluate: load the point window, then DEGREE*(DEGREE+1)/2 triangle steps, each a
// bit-serial divide, then one multiply and one accumulate per axis.
// One word at a time; the next is taken once the result sits in the output register.
// Synchronous active-low reset empties the spline; point stores are not cleared.
module bspline_de_boor_evaluator
    import bdb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [CMDW-1:0]        i_command,
    input  logic signed [PTW-1:0]  i_point_x,
    input  logic signed [PTW-1:0]  i_point_y,
    input  logic signed [PTW-1:0]  i_point_z,
    input  logic [XW-1:0]          i_param_value,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [PTW-1:0]  o_curve_x,
    output logic signed [PTW-1:0]  o_curve_y,
    output logic signed [PTW-1:0]  o_curve_z,
    output logic [STW-1:0]         o_status
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_WRITE = 9'b000000010,
        S_LOAD  = 9'b000000100,
        S_PREP  = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_ACC   = 9'b001000000,
        S_SHIFT = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    localparam logic signed [PW-1:0] SAT_HI   = PW'(32'sh7FFF_FFFF);
    localparam logic signed [PW-1:0] SAT_LO   = PW'(32'sh8000_0000);
    localparam logic signed [PW-1:0] RND_HALF = PW'(2 ** (FRAC_BITS - 1));

    t_state r_state, n_state;

    logic signed [PTW-1:0] r_px, r_py, r_pz;
    logic [XW-1:0]         r_x;
    logic [CW-1:0]         r_count;
    logic                  r_empty;
    logic [AW-1:0]         r_waddr, r_wend, r_base;
    logic [LW-1:0]         r_cnt;
    logic [KW-1:0]         r_k, r_i;
    logic [1:0]            r_ax;
    logic [CW-1:0]         r_rem, r_den;
    logic [XW-1:0]         r_quo;
    logic [QCW-1:0]        r_dcnt;
    logic signed [PW-1:0]  r_prod;
    logic signed [PTW-1:0] r_res [3];
    logic signed [PTW-1:0] r_wk  [3][DEGREE+1];
    logic [STW-1:0]        r_status;
    logic                  r_out_valid;
    logic signed [PTW-1:0] r_out_x, r_out_y, r_out_z;
    logic [STW-1:0]        r_out_status;

    logic                  accept, out_load, wr_en;
    logic [AW-1:0]         rd_addr;
    logic [PTW-1:0]        rd_x, rd_y, rd_z;
    logic [XW-1:0]         xi, lim;
    logic [AW-1:0]         base_c;
    logic [IW-1:0]         jj, jk;
    logic [CW-1:0]         knot_lo, knot_hi, den_raw, den;
    logic [NUMW-1:0]       lo_fix, x_ext;
    logic [XW-1:0]         num, dividend;
    logic [CW:0]           rem_sh, rem_nx;
    logic                  q_bit;
    logic signed [DW-1:0]  diff;
    logic signed [PW-1:0]  mag, rnd_p, rnd_n, rnd, sum;
    logic signed [PTW-1:0] sat_val;
    logic                  row_last;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign out_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);
    assign wr_en    = (r_state == S_WRITE);
    assign rd_addr  = r_base + AW'(r_cnt);

    // Point stores, one per axis
    bdb_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_ram_x (
        .i_clk(i_clk), .i_wr_en(wr_en), .i_wr_addr(r_waddr), .i_wr_data(r_px),
        .i_rd_addr(rd_addr), .o_rd_data(rd_x)
    );
    bdb_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_ram_y (
        .i_clk(i_clk), .i_wr_en(wr_en), .i_wr_addr(r_waddr), .i_wr_data(r_py),
        .i_rd_addr(rd_addr), .o_rd_data(rd_y)
    );
    bdb_ram #(.WIDTH(PTW), .DEPTH(MAX_POINTS)) u_ram_z (
        .i_clk(i_clk), .i_wr_en(wr_en), .i_wr_addr(r_waddr), .i_wr_data(r_pz),
        .i_rd_addr(rd_addr), .o_rd_data(rd_z)
    );

    // Locate the knot interval: first point of the active window
    always_comb begin
        xi     = XW'(i_param_value >> FRAC_BITS);
        lim    = XW'(r_count) - XW'(DEGREE + 1);
        base_c = AW'((xi < lim) ? xi : lim);
    end

    // Weight dividend and divisor for the current triangle step
    always_comb begin
        jj       = IW'(r_base) + IW'(DEGREE + 1) - IW'(r_k) + IW'(r_i);
        jk       = jj + IW'(r_k);
        knot_lo  = knot_at(jj, r_count);
        knot_hi  = knot_at(jk, r_count);
        den_raw  = knot_hi - knot_lo;
        den      = (den_raw == '0) ? CW'(1) : den_raw;
        lo_fix   = NUMW'(knot_lo) << FRAC_BITS;
        x_ext    = NUMW'(r_x);
        num      = (x_ext >= lo_fix) ? XW'(x_ext - lo_fix) : '0;
        dividend = num + XW'(den >> 1);
    end

    // One restoring divide step
    always_comb begin
        rem_sh = {r_rem, r_quo[XW-1]};
        q_bit  = (rem_sh >= {1'b0, r_den});
        rem_nx = q_bit ? (rem_sh - {1'b0, r_den}) : rem_sh;
    end

    // Difference, rounding and saturation for the axis at the head of the rotation
    always_comb begin
        diff  = DW'(r_wk[0][1]) - DW'(r_wk[0][0]);
        mag   = -r_prod;
        rnd_p = (r_prod + RND_HALF) >>> FRAC_BITS;
        rnd_n = -((mag + RND_HALF) >>> FRAC_BITS);
        rnd   = r_prod[PW-1] ? rnd_n : rnd_p;
        sum   = PW'(r_wk[0][0]) + rnd;
        if (sum > SAT_HI) begin
            sat_val = 32'sh7FFF_FFFF;
        end else if (sum < SAT_LO) begin
            sat_val = 32'sh8000_0000;
        end else begin
            sat_val = PTW'(sum);
        end
        row_last = (r_i == (r_k - KW'(1)));
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        CMD_ADD: begin
                            if (!r_empty && r_count >= CW'(MAX_POINTS)) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_WRITE;
                            end
                        end
                        CMD_RESET: n_state = S_DONE;
                        default: begin
                            if (r_empty || r_count <= CW'(DEGREE)) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_LOAD;
                            end
                        end
                    endcase
                end
            end
            S_WRITE: if (r_waddr == r_wend) n_state = S_DONE;
            S_LOAD:  if (r_cnt == LW'(DEGREE + 1)) n_state = S_PREP;
            S_PREP:  n_state = S_DIV;
            S_DIV:   if (r_dcnt == '0) n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = (r_ax == 2'd2) ? S_SHIFT : S_MUL;
            S_SHIFT: n_state = (row_last && r_k == KW'(1)) ? S_DONE : S_PREP;
            S_DONE:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_empty     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && i_command == CMD_RESET) begin
                r_count <= '0;
                r_empty <= 1'b1;
            end
            if (r_state == S_WRITE && r_waddr == r_wend) begin
                r_count <= r_empty ? CW'(DEGREE + 1) : r_count + CW'(1);
                r_empty <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // Latch the word and set up the command
                if (accept) begin
                    r_px <= i_point_x;
                    r_py <= i_point_y;
                    r_pz <= i_point_z;
                    r_x  <= i_param_value;
                    case (i_command)
                        CMD_ADD: begin
                            if (r_empty) begin
                                r_waddr  <= '0;
                                r_wend   <= AW'(DEGREE);
                                r_status <= ST_ADDED;
                            end else if (r_count >= CW'(MAX_POINTS)) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_waddr  <= AW'(r_count);
                                r_wend   <= AW'(r_count);
                                r_status <= ST_ADDED;
                            end
                        end
                        CMD_RESET: r_status <= ST_RESET;
                        default: begin
                            if (r_empty || r_count <= CW'(DEGREE)) begin
                                r_status <= ST_EMPTY;
                            end else begin
                                r_status <= ST_POINT;
                                r_base   <= base_c;
                                r_cnt    <= '0;
                                r_k      <= KW'(DEGREE);
                                r_i      <= '0;
                            end
                        end
                    endcase
                end
            end
            S_WRITE: begin
                // Advance through the entries being filled
                r_waddr <= r_waddr + AW'(1);
            end
            S_LOAD: begin
                // Shift the window of points into the working arrays
                if (r_cnt != '0) begin
                    for (int a = 0; a < 3; a++) begin
                        for (int m = 0; m < DEGREE; m++) begin
                            r_wk[a][m] <= r_wk[a][m+1];
                        end
                    end
                    r_wk[0][DEGREE] <= rd_x;
                    r_wk[1][DEGREE] <= rd_y;
                    r_wk[2][DEGREE] <= rd_z;
                end
                r_cnt <= r_cnt + LW'(1);
            end
            S_PREP: begin
                r_quo  <= dividend;
                r_rem  <= '0;
                r_den  <= den;
                r_dcnt <= QCW'(XW - 1);
            end
            S_DIV: begin
                r_rem  <= CW'(rem_nx);
                r_quo  <= {r_quo[XW-2:0], q_bit};
                r_dcnt <= r_dcnt - QCW'(1);
                r_ax   <= '0;
            end
            S_MUL: begin
                r_prod <= diff * $signed({1'b0, r_quo});
            end
            S_ACC: begin
                // Collect the result and rotate the next axis to the head
                r_res[2] <= sat_val;
                r_res[1] <= r_res[2];
                r_res[0] <= r_res[1];
                r_wk[0]  <= r_wk[1];
                r_wk[1]  <= r_wk[2];
                r_wk[2]  <= r_wk[0];
                r_ax     <= r_ax + 2'd1;
            end
            S_SHIFT: begin
                // Drop the consumed point and place the new one in the row
                for (int a = 0; a < 3; a++) begin
                    for (int m = 0; m <= DEGREE; m++) begin
                        if (row_last) begin
                            if (KW'(m) == r_k - KW'(1)) begin
                                r_wk[a][m] <= r_res[a];
                            end else begin
                                r_wk[a][m] <= r_wk[a][(m + 2 <= DEGREE) ? m + 2 : m];
                            end
                        end else begin
                            if (KW'(m) == r_k) begin
                                r_wk[a][m] <= r_res[a];
                            end else begin
                                r_wk[a][m] <= r_wk[a][(m + 1 <= DEGREE) ? m + 1 : m];
                            end
                        end
                    end
                end
                if (row_last) begin
                    r_k <= r_k - KW'(1);
                    r_i <= '0;
                end else begin
                    r_i <= r_i + KW'(1);
                end
            end
            S_DONE: begin
                // Hold the result until the output register is free
                if (out_load) begin
                    r_out_status <= r_status;
                    if (r_status == ST_POINT) begin
                        r_out_x <= r_res[0];
                        r_out_y <= r_res[1];
                        r_out_z <= r_res[2];
                    end else begin
                        r_out_x <= '0;
                        r_out_y <= '0;
                        r_out_z <= '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid   = r_out_valid;
    assign o_curve_x = r_out_x;
    assign o_curve_y = r_out_y;
    assign o_curve_z = r_out_z;
    assign o_status  = r_out_status;

endmodule

### tb/testbench.sv
// Self-checking bench for the clamped B-spline de Boor evaluator.
// Depends on bdb_pkg and bspline_de_boor_evaluator; predicts every result word itself.
`timescale 1ns / 100ps

module testbench;
    import bdb_pkg::*;

    typedef struct {
        logic [CMDW-1:0] cmd;
        logic [PTW-1:0]  px;
        logic [PTW-1:0]  py;
        logic [PTW-1:0]  pz;
        logic [XW-1:0]   par;
        bit              drain;
    } t_cmd_word;

    typedef struct {
        logic [PTW-1:0] cx;
        logic [PTW-1:0] cy;
        logic [PTW-1:0] cz;
        logic [STW-1:0] st;
    } t_curve_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [CMDW-1:0]       i_command = CMD_ADD;
    logic signed [PTW-1:0] i_point_x = '0;
    logic signed [PTW-1:0] i_point_y = '0;
    logic signed [PTW-1:0] i_point_z = '0;
    logic [XW-1:0]         i_param_value = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic signed [PTW-1:0] o_curve_x;
    logic signed [PTW-1:0] o_curve_y;
    logic signed [PTW-1:0] o_curve_z;
    logic [STW-1:0]        o_status;

    bspline_de_boor_evaluator dut (.*);

    t_cmd_word   pending_words[$];
    t_curve_word curve_expect[$];
    t_cmd_word   cur_word;
    int          mismatch_count = 0;
    int          words_sent = 0;
    int          evals_done = 0;
    int          cycle_no = 0;
    bit          stim_done = 1'b0;
    bit          took_word = 1'b0;

    // Predictor copy of the spline
    int          ctrl_x[MAX_POINTS];
    int          ctrl_y[MAX_POINTS];
    int          ctrl_z[MAX_POINTS];
    int          pt_count = 0;
    bit          spline_empty = 1'b1;

    always #1 i_clk = ~i_clk;

    function automatic longint knot_q(int i, int n);
        int k;
        if (i <= DEGREE) k = 0;
        else if (i >= n) k = n - DEGREE;
        else k = i - DEGREE;
        return longint'(k) <<< FRAC_BITS;
    endfunction

    function automatic int ctrl_read(int ax, int p);
        if (ax == 0) return ctrl_x[p];
        if (ax == 1) return ctrl_y[p];
        return ctrl_z[p];
    endfunction

    // De Boor triangle on one axis
    function automatic int de_boor_axis(int ax, int idx, int n, longint x);
        longint a[DEGREE+1];
        longint lo, hi, den, num, w, prod, r, s;
        longint half;
        int jj;
        half = longint'(1) <<< (FRAC_BITS - 1);
        for (int j = 0; j <= DEGREE; j++) a[DEGREE-j] = ctrl_read(ax, idx - j);
        for (int k = DEGREE; k > 0; k--) begin
            jj = idx - k;
            for (int i = 0; i < k; i++) begin
                jj++;
                lo = knot_q(jj, n);
                hi = knot_q(jj + k, n);
                den = (hi - lo) >>> FRAC_BITS;
                if (den == 0) den = 1;
                num = (x >= lo) ? x - lo : 0;
                w = (num + den / 2) / den;
                prod = (a[i+1] - a[i]) * w;
                if (prod >= 0) r = (prod + half) >>> FRAC_BITS;
                else r = -((-prod + half) >>> FRAC_BITS);
                s = a[i] + r;
                if (s > 64'sd2147483647) s = 64'sd2147483647;
                if (s < -64'sd2147483648) s = -64'sd2147483648;
                a[i] = s;
            end
        end
        return int'(a[0]);
    endfunction

    // Advance the spline state and work out the result word
    function automatic t_curve_word predict_curve(t_cmd_word w);
        t_curve_word res;
        int idx;
        longint x;
        res.cx = '0; res.cy = '0; res.cz = '0;
        if (w.cmd == CMD_ADD) begin
            if (spline_empty) begin
                for (int i = 0; i <= DEGREE; i++) begin
                    ctrl_x[i] = w.px; ctrl_y[i] = w.py; ctrl_z[i] = w.pz;
                end
                pt_count = DEGREE + 1;
                spline_empty = 1'b0;
                res.st = ST_ADDED;
            end else if (pt_count >= MAX_POINTS) begin
                res.st = ST_FULL;
            end else begin
                ctrl_x[pt_count] = w.px; ctrl_y[pt_count] = w.py; ctrl_z[pt_count] = w.pz;
                pt_count++;
                res.st = ST_ADDED;
            end
        end else if (w.cmd == CMD_RESET) begin
            pt_count = 0;
            spline_empty = 1'b1;
            res.st = ST_RESET;
        end else if (spline_empty || pt_count <= DEGREE) begin
            res.st = ST_EMPTY;
        end else begin
            x = longint'(w.par);
            idx = pt_count - 1;
            while (idx > DEGREE && x < knot_q(idx, pt_count)) idx--;
            res.cx = de_boor_axis(0, idx, pt_count, x);
            res.cy = de_boor_axis(1, idx, pt_count, x);
            res.cz = de_boor_axis(2, idx, pt_count, x);
            res.st = ST_POINT;
        end
        return res;
    endfunction

    task automatic queue_word(logic [CMDW-1:0] c, logic [PTW-1:0] x, logic [PTW-1:0] y,
                              logic [PTW-1:0] z, logic [XW-1:0] p, bit d);
        t_cmd_word w;
        w.cmd = c; w.px = x; w.py = y; w.pz = z; w.par = p; w.drain = d;
        pending_words.push_back(w);
    endtask

    function automatic logic [PTW-1:0] rand_coord();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return PTW'(int'($urandom) >>> $urandom_range(8, 14));
    endfunction

    function automatic logic [XW-1:0] rand_param(int n);
        int top;
        top = (n > DEGREE) ? ((n - DEGREE) << FRAC_BITS) : 65536;
        if ($urandom_range(0, 5) == 0) return XW'($urandom_range(0, 4194304));
        return XW'($urandom_range(0, (top > 4194304) ? 4194304 : top));
    endfunction

    task automatic report_mismatch(string what, logic [PTW-1:0] got, logic [PTW-1:0] want);
        $display("mismatch %0s: got %h want %h at cycle %0d", what, got, want, cycle_no);
        mismatch_count++;
    endtask

    function automatic bit quiet_phase();
        return cycle_no >= 20000 && cycle_no < 40000;
    endfunction

    // Fill the word queue
    initial begin
        int n, m, e;
        // Directed: empty evaluate, extremes, beyond last knot, command three, refill
        queue_word(CMD_EVAL, '0, '0, '0, '0, 1'b0);
        queue_word(CMD_ADD, 32'h7fffffff, 32'h80000000, '0, '0, 1'b0);
        queue_word(CMD_EVAL, '0, '0, '0, 23'd32768, 1'b0);
        queue_word(CMD_ADD, 32'h80000000, 32'h7fffffff, 32'hffffffff, '0, 1'b0);
        queue_word(CMD_ADD, 32'h00010000, 32'hffff0000, 32'h7fffffff, '0, 1'b0);
        queue_word(CMD_EVAL, '0, '0, '0, '0, 1'b0);
        queue_word(CMD_EVAL, '0, '0, '0, 23'd4194304, 1'b0);
        queue_word(2'd3, '0, '0, '0, 23'd98304, 1'b0);
        queue_word(CMD_EVAL, '0, '0, '0, 23'd131072, 1'b0);
        queue_word(CMD_RESET, '0, '0, '0, '0, 1'b0);
        queue_word(CMD_EVAL, '0, '0, '0, 23'd65536, 1'b1);
        queue_word(CMD_ADD, 32'h00020000, 32'h00030000, 32'hfffc0000, '0, 1'b0);
        queue_word(CMD_EVAL, '0, '0, '0, 23'h3fffff, 1'b0);
        // Random spline sessions
        n = 0;
        while (pending_words.size() < 700) begin
            if ($urandom_range(0, 3) != 0) begin
                queue_word(CMD_RESET, $urandom, $urandom, $urandom, XW'($urandom), 1'b0);
                n = 0;
            end
            m = ($urandom_range(0, 9) == 0) ? 70 : $urandom_range(1, 8);
            for (int i = 0; i < m; i++) begin
                queue_word(CMD_ADD, rand_coord(), rand_coord(), rand_coord(), XW'($urandom),
                           1'b0);
                if (n == 0) n = DEGREE + 1;
                else if (n < MAX_POINTS) n++;
            end
            e = $urandom_range(1, 6);
            for (int i = 0; i < e; i++)
                queue_word(($urandom_range(0, 7) == 0) ? 2'd3 : CMD_EVAL, $urandom, $urandom,
                           $urandom, rand_param(n), $urandom_range(0, 40) == 0);
            if ($urandom_range(0, 6) == 0)
                queue_word(CMD_EVAL, '0, '0, '0, XW'($urandom), 1'b0);
        end
        stim_done = 1'b1;
    end

    // Reset and cycle count
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) cycle_no <= cycle_no + 1;

    // Record accepted words and predict
    always @(posedge i_clk) begin
        took_word <= 1'b0;
        if (i_rst_n && i_valid && !o_stall) begin
            curve_expect.push_back(predict_curve(cur_word));
            words_sent <= words_sent + 1;
            if (cur_word.cmd[0]) evals_done <= evals_done + 1;
            took_word <= 1'b1;
        end
    end

    // Drive command words
    always @(negedge i_clk) begin
        i_stall <= quiet_phase() ? 1'b0 : ($urandom_range(0, 99) < 13);
        if (i_rst_n && (!i_valid || took_word)) begin
            if (pending_words.size() > 0 &&
                (!pending_words[0].drain || curve_expect.size() == 0) &&
                (quiet_phase() || $urandom_range(0, 99) >= 13)) begin
                cur_word = pending_words.pop_front();
                i_command <= cur_word.cmd;
                i_point_x <= cur_word.px;
                i_point_y <= cur_word.py;
                i_point_z <= cur_word.pz;
                i_param_value <= cur_word.par;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Check result words
    always @(posedge i_clk) begin
        t_curve_word exp_w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (curve_expect.size() == 0) begin
                report_mismatch("unexpected word status", PTW'(o_status), '0);
            end else begin
                exp_w = curve_expect.pop_front();
                if (o_status !== exp_w.st) report_mismatch("status", PTW'(o_status), PTW'(exp_w.st));
                if (o_curve_x !== exp_w.cx) report_mismatch("curve x", o_curve_x, exp_w.cx);
                if (o_curve_y !== exp_w.cy) report_mismatch("curve y", o_curve_y, exp_w.cy);
                if (o_curve_z !== exp_w.cz) report_mismatch("curve z", o_curve_z, exp_w.cz);
            end
        end
    end

    // Finish once everything has drained
    initial begin
        wait (stim_done && pending_words.size() == 0 && !i_valid && curve_expect.size() == 0);
        repeat (300) @(posedge i_clk);
        if (curve_expect.size() != 0) begin
            $display("%0d result words never arrived", curve_expect.size());
            mismatch_count++;
        end
        $display("covered %0d command words, %0d of them evaluate, over %0d cycles",
                 words_sent, evals_done, cycle_no);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard limit on run time
    initial begin
        #2000000;
        $display("timeout with %0d words pending", pending_words.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### bspline_de_boor_evaluator.f
hdl/bdb_pkg.sv
hdl/bdb_ram.sv
hdl/bspline_de_boor_evaluator.sv
tb/testbench.sv
